>>> rtl/core/rfm_pkg.sv
// shared types and constants of the reciprocal frequency meter
package rfm_pkg;

    localparam int unsigned DIV_W    = 32;
    localparam int unsigned CNT_W    = $clog2(DIV_W);
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned RATE_W   = 27;
    localparam int unsigned SPP_W    = 12;
    localparam int unsigned RELOAD_W = 16;
    localparam int unsigned WRAPS_W  = 9;
    localparam int unsigned CAP_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // ticks added to the period accumulator on each timer wrap
    localparam logic [CAP_W-1:0]    WRAP_TICKS  = 16'd65535;
    // one full sample timer wrap
    localparam logic [DIV_W-1:0]    SAMPLE_WRAP = 32'h0000_FFFF;
    localparam logic [WRAPS_W-1:0]  WRAPS_MAX   = 9'd511;

    localparam logic [RATE_W-1:0]   RST_CLOCK_RATE = 27'd24000000;
    localparam logic [ACC_W-1:0]    RST_DC_LIMIT   = 32'd306500;
    localparam logic [SPP_W-1:0]    RST_SPP        = 12'd240;
    localparam logic [RELOAD_W-1:0] RST_MIN_RELOAD = 16'd90;
    localparam logic [RELOAD_W-1:0] RST_DC_RELOAD  = 16'd3395;
    localparam logic [WRAPS_W-1:0]  RST_DC_WRAPS   = 9'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_RATE = 3'd0,
        CFG_DC_LIMIT   = 3'd1,
        CFG_SPP        = 3'd2,
        CFG_MIN_RELOAD = 3'd3,
        CFG_DC_RELOAD  = 3'd4,
        CFG_DC_WRAPS   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> rtl/core/rfm_div.sv
// shared restoring divider, one quotient bit per cycle
module rfm_div
    import rfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

>>> rtl/core/reciprocal_frequency_meter.sv
// reciprocal frequency meter: period accumulation, frequency and sample interval
//
// Input channel (i_in_valid / o_in_stall) carries one event per transaction:
// i_func = 0 is a timer wrap, i_func = 1 a rising edge with its capture count.
// Output channel (o_out_valid / i_out_stall) returns exactly one result for
// every event. Registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. One event is handled at a time;
// o_in_stall is high from acceptance until the result has been taken. Both
// divisions go through one restoring divider that yields one quotient bit per
// cycle. In DC mode the result follows straight on the evaluation; otherwise
// the frequency division and the sample-interval division come first, and,
// when the interval needs wraps, a fold step splits it into 0xFFFF-tick wraps.
// The result then waits as long as the receiver stalls. The next event is
// accepted the cycle after the result is taken.
// The result stays on the output ports, unchanged, while i_out_stall is high.
// Reset (synchronous, active low) clears the accumulator and the last period,
// loads the default register values and leaves the block idle.
module reciprocal_frequency_meter
    import rfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [CAP_W-1:0]      i_capture_count,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ACC_W-1:0]      o_period_ticks,
    output logic [RATE_W-1:0]     o_frequency,
    output logic                  o_dc_mode,
    output logic [WRAPS_W-1:0]    o_sample_wraps,
    output logic [RELOAD_W-1:0]   o_sample_reload
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_FREQ = 6'b000100,
        S_SAMP = 6'b001000,
        S_WRAP = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;

    logic [RATE_W-1:0]   r_clock_rate;
    logic [ACC_W-1:0]    r_dc_limit;
    logic [SPP_W-1:0]    r_spp;
    logic [RELOAD_W-1:0] r_min_reload;
    logic [RELOAD_W-1:0] r_dc_reload;
    logic [WRAPS_W-1:0]  r_dc_wraps;

    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_last;

    logic [ACC_W-1:0]    r_shown;
    logic [RATE_W-1:0]   r_freq;
    logic                r_dc;
    logic [WRAPS_W-1:0]  r_wraps;
    logic [RELOAD_W-1:0] r_reload;

    logic                r_div_go;
    logic [DIV_W-1:0]    r_div_dividend;
    logic [DIV_W-1:0]    r_div_divisor;
    logic [DIV_W-1:0]    r_wrap_x;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [ACC_W:0]      w_sum;
    logic [ACC_W-1:0]    w_sat;
    logic [DIV_W-1:0]    w_q;
    logic [SPP_W-1:0]    w_spp;

    logic [RELOAD_W:0]   w_fold;
    logic [1:0]          w_fold_k;
    logic [RELOAD_W-1:0] w_fold_rem;
    logic [RELOAD_W:0]   w_wrap_cnt;

    assign w_div_req.go       = r_div_go;
    assign w_div_req.dividend = r_div_dividend;
    assign w_div_req.divisor  = r_div_divisor;

    rfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // saturating add of the wrap ticks or the capture count
    assign w_sum = {1'b0, r_acc} + {{(ACC_W+1-CAP_W){1'b0}},
                                    (i_func ? i_capture_count : WRAP_TICKS)};
    assign w_sat = w_sum[ACC_W] ? {ACC_W{1'b1}} : w_sum[ACC_W-1:0];
    assign w_q   = w_div_rsp.quot;
    assign w_spp = (r_spp == '0) ? SPP_W'(1) : r_spp;

    // x / 0xFFFF by folding: x = hi * 0xFFFF + (hi + lo), hi + lo holds at most two wraps
    assign w_fold     = {1'b0, r_wrap_x[DIV_W-1:RELOAD_W]} + {1'b0, r_wrap_x[RELOAD_W-1:0]};
    assign w_fold_k   = (w_fold == {SAMPLE_WRAP[RELOAD_W-1:0], 1'b0}) ? 2'd2 :
                        (w_fold >= {1'b0, SAMPLE_WRAP[RELOAD_W-1:0]}) ? 2'd1 : 2'd0;
    // one wrap off: fold - 0xFFFF equals fold + 1 in the low 16 bits
    assign w_fold_rem = (w_fold_k == 2'd2) ? '0 :
                        (w_fold_k == 2'd1) ? (w_fold[RELOAD_W-1:0] + RELOAD_W'(1)) :
                        w_fold[RELOAD_W-1:0];
    assign w_wrap_cnt = {1'b0, r_wrap_x[DIV_W-1:RELOAD_W]} + {{(RELOAD_W-1){1'b0}}, w_fold_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= RST_CLOCK_RATE;
            r_dc_limit   <= RST_DC_LIMIT;
            r_spp        <= RST_SPP;
            r_min_reload <= RST_MIN_RELOAD;
            r_dc_reload  <= RST_DC_RELOAD;
            r_dc_wraps   <= RST_DC_WRAPS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLOCK_RATE: r_clock_rate <= i_cfg_data[RATE_W-1:0];
                CFG_DC_LIMIT:   r_dc_limit   <= i_cfg_data[ACC_W-1:0];
                CFG_SPP:        r_spp        <= i_cfg_data[SPP_W-1:0];
                CFG_MIN_RELOAD: r_min_reload <= i_cfg_data[RELOAD_W-1:0];
                CFG_DC_RELOAD:  r_dc_reload  <= i_cfg_data[RELOAD_W-1:0];
                CFG_DC_WRAPS:   r_dc_wraps   <= i_cfg_data[WRAPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_last   <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_func) begin
                            r_last <= w_sat;
                            r_acc  <= '0;
                        end else begin
                            r_acc <= w_sat;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_acc >= r_dc_limit) begin
                        r_state <= S_OUT;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_FREQ;
                    end
                end
                S_FREQ: begin
                    if (w_div_rsp.done) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_SAMP;
                    end
                end
                S_SAMP: begin
                    if (w_div_rsp.done) begin
                        if (|w_q[DIV_W-1:RELOAD_W]) begin
                            r_state <= S_WRAP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WRAP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload of the divider request and of the result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_shown <= w_sat;
            end
            S_EVAL: begin
                r_dc           <= (r_acc >= r_dc_limit);
                r_freq         <= '0;
                r_wraps        <= r_dc_wraps;
                r_reload       <= r_dc_reload;
                r_div_dividend <= {{(DIV_W-RATE_W){1'b0}}, r_clock_rate};
                r_div_divisor  <= r_last;
            end
            S_FREQ: begin
                if (w_div_rsp.done) begin
                    r_freq         <= (r_last == '0) ? '0 : w_q[RATE_W-1:0];
                    r_div_dividend <= r_last;
                    r_div_divisor  <= {{(DIV_W-SPP_W){1'b0}}, w_spp};
                end
            end
            S_SAMP: begin
                if (w_div_rsp.done) begin
                    r_wraps  <= '0;
                    r_reload <= (w_q[RELOAD_W-1:0] < r_min_reload) ?
                                r_min_reload : w_q[RELOAD_W-1:0];
                    r_wrap_x <= w_q - DIV_W'(1);
                end
            end
            S_WRAP: begin
                if (w_wrap_cnt > {{(RELOAD_W+1-WRAPS_W){1'b0}}, WRAPS_MAX}) begin
                    r_wraps  <= WRAPS_MAX;
                    r_reload <= SAMPLE_WRAP[RELOAD_W-1:0];
                end else begin
                    r_wraps  <= w_wrap_cnt[WRAPS_W-1:0];
                    // remainder stays below 0xFFFF, so the increment fits
                    r_reload <= w_fold_rem + RELOAD_W'(1);
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_period_ticks  = r_shown;
    assign o_frequency     = r_freq;
    assign o_dc_mode       = r_dc;
    assign o_sample_wraps  = r_wraps;
    assign o_sample_reload = r_reload;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_dc_no_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dc_mode) |-> (o_frequency == '0))
        else $error("frequency reported in dc mode");

    a_wrap_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_dc_mode && (o_sample_wraps != '0)) |->
        (o_sample_reload != '0))
        else $error("zero reload with sample wraps");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_FREQ || r_state == S_SAMP))
        else $error("divider finished outside a wait state");

    a_go_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EVAL && !r_div_go))
        else $error("transaction did not enter evaluation");

endmodule

>>> sim/tb_reciprocal_frequency_meter.sv
// testbench of the reciprocal frequency meter: directed and random events against a predictor
`timescale 1ns / 1ps

module tb_reciprocal_frequency_meter;
    import rfm_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned RANDOM_EVENTS = 720;
    localparam int unsigned RANDOM_PHASES = 8;

    typedef struct packed {
        logic [ACC_W-1:0]    period_ticks;
        logic [RATE_W-1:0]   frequency;
        logic                dc_mode;
        logic [WRAPS_W-1:0]  sample_wraps;
        logic [RELOAD_W-1:0] sample_reload;
    } t_meter_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_func = 1'b0;
    logic [CAP_W-1:0]      in_capture = '0;
    logic                  out_stall = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [ACC_W-1:0]      o_period_ticks;
    logic [RATE_W-1:0]     o_frequency;
    logic                  o_dc_mode;
    logic [WRAPS_W-1:0]    o_sample_wraps;
    logic [RELOAD_W-1:0]   o_sample_reload;

    // predictor copy of the registers and the period state
    logic [RATE_W-1:0]     rate_reg;
    logic [ACC_W-1:0]      dc_limit_reg;
    logic [SPP_W-1:0]      spp_reg;
    logic [RELOAD_W-1:0]   min_reload_reg;
    logic [RELOAD_W-1:0]   dc_reload_reg;
    logic [WRAPS_W-1:0]    dc_wraps_reg;
    logic [ACC_W-1:0]      accum_ticks;
    logic [ACC_W-1:0]      closed_period;

    t_meter_result         pending_results[$];
    t_meter_result         oldest;
    int unsigned           mismatches = 0;
    int unsigned           events_sent = 0;
    int unsigned           cycle_count = 0;
    int unsigned           send_gap_pct = 0;
    int unsigned           recv_stall_pct = 0;

    reciprocal_frequency_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (in_func),
        .i_capture_count (in_capture),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_period_ticks  (o_period_ticks),
        .o_frequency     (o_frequency),
        .o_dc_mode       (o_dc_mode),
        .o_sample_wraps  (o_sample_wraps),
        .o_sample_reload (o_sample_reload)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_reciprocal_frequency_meter NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // updates the period state for one event and returns the result it causes
    function automatic t_meter_result measure_event(input logic is_edge,
                                                    input logic [CAP_W-1:0] capture);
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] divisor;
        logic [ACC_W-1:0] interval;
        logic [ACC_W-1:0] wraps;
        logic [ACC_W-1:0] reload;
        t_meter_result    res;
        if (!is_edge) begin
            sum = {1'b0, accum_ticks} + WRAP_TICKS;
            accum_ticks = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            res.period_ticks = accum_ticks;
        end else begin
            sum = {1'b0, accum_ticks} + capture;
            closed_period = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            accum_ticks = '0;
            res.period_ticks = closed_period;
        end
        res.dc_mode = (accum_ticks >= dc_limit_reg);
        if (res.dc_mode) begin
            res.frequency     = '0;
            res.sample_wraps  = dc_wraps_reg;
            res.sample_reload = dc_reload_reg;
        end else begin
            res.frequency = (closed_period == 0) ? '0
                          : RATE_W'({5'b0, rate_reg} / closed_period);
            divisor  = (spp_reg == 0) ? 32'd1 : 32'(spp_reg);
            interval = closed_period / divisor;
            if (interval > SAMPLE_WRAP) begin
                wraps  = (interval - 1) / SAMPLE_WRAP;
                reload = interval - wraps * SAMPLE_WRAP;
            end else begin
                wraps  = '0;
                reload = interval;
            end
            if (wraps > WRAPS_MAX) begin
                wraps  = 32'(WRAPS_MAX);
                reload = SAMPLE_WRAP;
            end
            if (wraps == 0 && reload < min_reload_reg)
                reload = 32'(min_reload_reg);
            res.sample_wraps  = wraps[WRAPS_W-1:0];
            res.sample_reload = reload[RELOAD_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no event pending");
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_period_ticks !== oldest.period_ticks) begin
                    $error("period_ticks: expected %0d, actual %0d",
                           oldest.period_ticks, o_period_ticks);
                    mismatches++;
                end
                if (o_frequency !== oldest.frequency) begin
                    $error("frequency: expected %0d, actual %0d",
                           oldest.frequency, o_frequency);
                    mismatches++;
                end
                if (o_dc_mode !== oldest.dc_mode) begin
                    $error("dc_mode: expected %0d, actual %0d", oldest.dc_mode, o_dc_mode);
                    mismatches++;
                end
                if (o_sample_wraps !== oldest.sample_wraps) begin
                    $error("sample_wraps: expected %0d, actual %0d",
                           oldest.sample_wraps, o_sample_wraps);
                    mismatches++;
                end
                if (o_sample_reload !== oldest.sample_reload) begin
                    $error("sample_reload: expected %0d, actual %0d",
                           oldest.sample_reload, o_sample_reload);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_event(input logic is_edge, input logic [CAP_W-1:0] capture);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_func    <= is_edge;
        in_capture <= capture;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(measure_event(is_edge, capture));
        events_sent++;
    endtask

    task automatic send_wraps(input int unsigned count);
        repeat (count) send_event(1'b0, CAP_W'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CLOCK_RATE: rate_reg       = value[RATE_W-1:0];
            CFG_DC_LIMIT:   dc_limit_reg   = value[ACC_W-1:0];
            CFG_SPP:        spp_reg        = value[SPP_W-1:0];
            CFG_MIN_RELOAD: min_reload_reg = value[RELOAD_W-1:0];
            CFG_DC_RELOAD:  dc_reload_reg  = value[RELOAD_W-1:0];
            CFG_DC_WRAPS:   dc_wraps_reg   = value[WRAPS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CAP_W-1:0] random_capture();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 2)
            return '0;
        if (r < 4)
            return '1;
        return CAP_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned phase,
                                                            input logic [31:0] lo,
                                                            input logic [31:0] hi,
                                                            input logic [31:0] rnd_hi);
        int unsigned sel;
        sel = (phase == 1) ? 1 : (phase == 2) ? 0 : $urandom_range(3);
        case (sel)
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(rnd_hi, lo);
        endcase
    endfunction

    // default register values straight after reset, no period history
    task automatic test_basic_events();
        send_event(1'b1, 16'h0000);
        send_event(1'b1, 16'hFFFF);
        send_event(1'b1, 16'h0001);
        send_wraps(2);
        send_event(1'b1, 16'd100);
        // fifth wrap crosses the default dc limit
        send_wraps(5);
        send_event(1'b1, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_CLOCK_RATE, 32'd100000000);
        write_reg(CFG_SPP, 32'd1);
        write_reg(CFG_MIN_RELOAD, 32'd65535);
        write_reg(CFG_DC_RELOAD, 32'd65535);
        write_reg(CFG_DC_WRAPS, 32'd511);
        write_reg(CFG_DC_LIMIT, 32'hFFFF_FFFF);
        // interval exactly one sample wrap, then one tick over it
        send_wraps(1);
        send_event(1'b1, 16'd0);
        send_wraps(1);
        send_event(1'b1, 16'd1);
        send_event(1'b1, 16'd5);
        wait_idle();
        // zero divisor acts as one, zero period gives zero frequency
        write_reg(CFG_SPP, 32'd0);
        write_reg(CFG_MIN_RELOAD, 32'd0);
        send_event(1'b1, 16'd3);
        send_event(1'b1, 16'd0);
        wait_idle();
        // a zero dc limit keeps dc mode even after an edge
        write_reg(CFG_DC_LIMIT, 32'd0);
        write_reg(CFG_DC_WRAPS, 32'd0);
        write_reg(CFG_DC_RELOAD, 32'd0);
        write_reg(CFG_CLOCK_RATE, 32'd1);
        send_event(1'b1, 16'd7);
        send_wraps(1);
        wait_idle();
        write_reg(CFG_DC_LIMIT, 32'd1);
        send_event(1'b1, 16'd1);
        wait_idle();
    endtask

    task automatic test_wrap_count_saturation();
        write_reg(CFG_CLOCK_RATE, 32'(RST_CLOCK_RATE));
        write_reg(CFG_SPP, 32'd1);
        write_reg(CFG_MIN_RELOAD, 32'(RST_MIN_RELOAD));
        write_reg(CFG_DC_LIMIT, 32'hFFFF_FFFF);
        send_wraps(520);
        send_event(1'b1, 16'h1234);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int unsigned goal;
        int unsigned burst;
        int unsigned r;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 57; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 57; end
                default: begin send_gap_pct = 31; recv_stall_pct = 31; end
            endcase
            if (phase == 0) begin
                write_reg(CFG_CLOCK_RATE, 32'(RST_CLOCK_RATE));
                write_reg(CFG_DC_LIMIT, 32'(RST_DC_LIMIT));
                write_reg(CFG_SPP, 32'(RST_SPP));
                write_reg(CFG_MIN_RELOAD, 32'(RST_MIN_RELOAD));
                write_reg(CFG_DC_RELOAD, 32'(RST_DC_RELOAD));
                write_reg(CFG_DC_WRAPS, 32'(RST_DC_WRAPS));
            end else begin
                write_reg(CFG_CLOCK_RATE, pick_setting(phase, 1, 100000000, 100000000));
                write_reg(CFG_DC_LIMIT, pick_setting(phase, 1, 32'hFFFF_FFFF, 400000));
                write_reg(CFG_SPP, pick_setting(phase, 1, 4095, 4095));
                write_reg(CFG_MIN_RELOAD, pick_setting(phase, 0, 65535, 65535));
                write_reg(CFG_DC_RELOAD, pick_setting(phase, 0, 65535, 65535));
                write_reg(CFG_DC_WRAPS, pick_setting(phase, 0, 511, 511));
            end
            goal = events_sent + RANDOM_EVENTS / RANDOM_PHASES;
            while (events_sent < goal) begin
                r = $urandom_range(99);
                burst = (r < 60) ? $urandom_range(3)
                      : (r < 90) ? $urandom_range(12, 4) : $urandom_range(40, 13);
                send_wraps(burst);
                // most bursts close with an edge, a few are left open
                if ($urandom_range(9) != 0)
                    send_event(1'b1, random_capture());
            end
            wait_idle();
        end
    endtask

    initial begin
        rate_reg       = RST_CLOCK_RATE;
        dc_limit_reg   = RST_DC_LIMIT;
        spp_reg        = RST_SPP;
        min_reload_reg = RST_MIN_RELOAD;
        dc_reload_reg  = RST_DC_RELOAD;
        dc_wraps_reg   = RST_DC_WRAPS;
        accum_ticks    = '0;
        closed_period  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_events();
        test_register_extremes();
        test_wrap_count_saturation();
        test_random_phases();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_reciprocal_frequency_meter OK");
        end else begin
            $display("tb_reciprocal_frequency_meter NOT OK");
        end
        $finish;
    end

endmodule
